FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds in the same cycle whenever cond holds.
`define ASSERT_IMPLIES(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Check that expr holds in the cycle after cond.
`define ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: sv/post_pkg.sv
// ---------------------------------------------------------------------------
// post_pkg
// Shared types, codes and the sample conversion for the outlier spread test.
// ---------------------------------------------------------------------------
package post_pkg;

    localparam logic [63:0] RECORD_MARK = 64'h216C7174786A7A21;
    localparam logic [63:0] FRAC_MASK   = 64'h000FFFFFFFFFFFFF;
    localparam logic [63:0] HIDDEN_BIT  = 64'h0010000000000000;
    localparam logic [12:0] EXP_ANCHOR  = 13'd1065;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned FIX_W   = 32;
    localparam int unsigned SUM_W   = 35;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CFG_W   = 32;

    // Record positions: words taken so far in the current record.
    localparam logic [POS_W-1:0] POS_IDLE         = 5'd0;
    localparam logic [POS_W-1:0] POS_TAG          = 5'd1;
    localparam logic [POS_W-1:0] POS_FIRST_SAMPLE = 5'd2;
    localparam logic [POS_W-1:0] POS_LAST_LOW     = 5'd9;
    localparam logic [POS_W-1:0] POS_LAST         = 5'd17;

    // What kind of word an item in flight is.
    localparam logic [1:0] KIND_MAGIC = 2'd0;
    localparam logic [1:0] KIND_TAG   = 2'd1;
    localparam logic [1:0] KIND_LOW   = 2'd2;
    localparam logic [1:0] KIND_HIGH  = 2'd3;

    localparam logic [1:0] VERDICT_UNTOUCHED = 2'd0;
    localparam logic [1:0] VERDICT_EXCEEDED  = 2'd1;
    localparam logic [1:0] VERDICT_WITHIN    = 2'd2;

    localparam logic CFG_DEVIATION_LIMIT = 1'b0;
    localparam logic CFG_SPREAD_WEIGHT   = 1'b1;

    localparam logic [CFG_W-1:0] DEVIATION_LIMIT_RESET = 32'd1638;
    localparam logic [CFG_W-1:0] SPREAD_WEIGHT_RESET   = 32'd2684191;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        verdict;
        logic [WORD_W-1:0] tag_out;
    } out_item_t;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       close_low;   // eighth sample: mean and spread settle
        logic       close_rec;   // last sample: result leaves
    } item_ctl_t;

    // Accumulated record statistics handed to the decision stage.
    typedef struct packed {
        logic [WORD_W-1:0]  square_sum;
        logic [WORD_W-1:0]  mean_sq;
        logic [COUNT_W-1:0] count;
    } stats_t;

    // Raw double bits to unsigned fixed point with 10 fraction bits.
    function automatic logic [FIX_W-1:0] to_fixed(input logic [WORD_W-1:0] w);
        logic [12:0]       e;
        logic [12:0]       s;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] shifted;
        e = {1'b0, w[63:52]};
        s = (EXP_ANCHOR > e) ? (EXP_ANCHOR - e) : (e - EXP_ANCHOR);
        m = (w & FRAC_MASK) | HIDDEN_BIT;
        shifted = m >> s[5:0];
        if (w == '0 || s[12:6] != '0) begin
            to_fixed = '0;
        end else begin
            to_fixed = shifted[FIX_W-1:0];
        end
    endfunction

endpackage

FILE: sv/post_front.sv
// ---------------------------------------------------------------------------
// post_front
// Record position tracking and the input register of the pipeline.
// ---------------------------------------------------------------------------
module post_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        s_valid,
    input  post_pkg::in_item_t          s_item,
    output post_pkg::item_ctl_t         r1_ctl,
    output logic [post_pkg::WORD_W-1:0] r1_word
);

    logic [post_pkg::POS_W-1:0] pos_reg;
    logic [post_pkg::POS_W-1:0] pos_next;
    post_pkg::item_ctl_t        ctl_next;
    post_pkg::item_ctl_t        r1_ctl_reg;
    logic [post_pkg::WORD_W-1:0] r1_word_reg;

    always_comb begin
        pos_next           = pos_reg;
        ctl_next           = '0;
        ctl_next.kind      = post_pkg::KIND_MAGIC;
        if (s_valid) begin
            if (s_item.first) begin
                ctl_next.valid = 1'b1;
                pos_next       = post_pkg::POS_TAG;
            end else begin
                case (pos_reg) inside
                    post_pkg::POS_IDLE: begin
                        // drop words outside a record
                    end
                    post_pkg::POS_TAG: begin
                        ctl_next.valid = 1'b1;
                        ctl_next.kind  = post_pkg::KIND_TAG;
                        pos_next       = post_pkg::POS_FIRST_SAMPLE;
                    end
                    [post_pkg::POS_FIRST_SAMPLE:post_pkg::POS_LAST_LOW]: begin
                        ctl_next.valid     = 1'b1;
                        ctl_next.kind      = post_pkg::KIND_LOW;
                        ctl_next.close_low = (pos_reg == post_pkg::POS_LAST_LOW);
                        pos_next           = pos_reg + 5'd1;
                    end
                    default: begin
                        ctl_next.valid     = 1'b1;
                        ctl_next.kind      = post_pkg::KIND_HIGH;
                        ctl_next.close_rec = (pos_reg == post_pkg::POS_LAST);
                        pos_next = ctl_next.close_rec ? post_pkg::POS_IDLE
                                                      : pos_reg + 5'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= post_pkg::POS_IDLE;
            r1_ctl_reg <= '0;
        end else if (adv) begin
            pos_reg    <= pos_next;
            r1_ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_word_reg <= s_item.word;
        end
    end

    assign r1_ctl  = r1_ctl_reg;
    assign r1_word = r1_word_reg;

endmodule

FILE: sv/post_convert.sv
// ---------------------------------------------------------------------------
// post_convert
// Converts sample words to fixed point; other words pass unchanged.
// ---------------------------------------------------------------------------
module post_convert (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  post_pkg::item_ctl_t         r1_ctl,
    input  logic [post_pkg::WORD_W-1:0] r1_word,
    output post_pkg::item_ctl_t         r2_ctl,
    output logic [post_pkg::WORD_W-1:0] r2_word,
    output logic [post_pkg::FIX_W-1:0]  r2_val
);

    post_pkg::item_ctl_t         r2_ctl_reg;
    logic [post_pkg::WORD_W-1:0] r2_word_reg;
    logic [post_pkg::FIX_W-1:0]  r2_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r2_ctl_reg <= '0;
        end else if (adv) begin
            r2_ctl_reg <= r1_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r2_word_reg <= r1_word;
            r2_val_reg  <= post_pkg::to_fixed(r1_word);
        end
    end

    assign r2_ctl  = r2_ctl_reg;
    assign r2_word = r2_word_reg;
    assign r2_val  = r2_val_reg;

endmodule

FILE: sv/post_stats.sv
// ---------------------------------------------------------------------------
// post_stats
// Sample sum, squares, mean square and outlier count over two stages.
// ---------------------------------------------------------------------------
module post_stats (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic [post_pkg::CFG_W-1:0]  deviation_limit,
    input  post_pkg::item_ctl_t         r2_ctl,
    input  logic [post_pkg::WORD_W-1:0] r2_word,
    input  logic [post_pkg::FIX_W-1:0]  r2_val,
    output post_pkg::item_ctl_t         r4_ctl,
    output logic [post_pkg::WORD_W-1:0] r4_word,
    output post_pkg::stats_t            stats
);

    // first stage: sum, square, outlier test
    logic [post_pkg::SUM_W-1:0]  sum_reg;
    post_pkg::item_ctl_t         r3_ctl_reg;
    logic [post_pkg::WORD_W-1:0] r3_word_reg;
    logic [post_pkg::WORD_W-1:0] r3_sq_reg;
    logic                        r3_outlier_reg;

    // second stage: square sum, mean square, count
    logic [post_pkg::WORD_W-1:0]  square_sum_reg;
    logic [post_pkg::WORD_W-1:0]  mean_sq_reg;
    logic [post_pkg::COUNT_W-1:0] count_reg;
    post_pkg::item_ctl_t          r4_ctl_reg;
    logic [post_pkg::WORD_W-1:0]  r4_word_reg;

    logic [post_pkg::FIX_W-1:0]  mean;
    logic [post_pkg::FIX_W-1:0]  distance;
    logic [post_pkg::WORD_W-1:0] val_wide;
    logic [post_pkg::WORD_W-1:0] mean_wide;
    logic [post_pkg::WORD_W-1:0] sq_next;
    logic [post_pkg::WORD_W-1:0] mean_sq_next;

    assign mean         = sum_reg[post_pkg::SUM_W-1:3];
    assign distance     = (r2_val >= mean) ? (r2_val - mean) : (mean - r2_val);
    assign val_wide     = {{(post_pkg::WORD_W-post_pkg::FIX_W){1'b0}}, r2_val};
    assign mean_wide    = {{(post_pkg::WORD_W-post_pkg::FIX_W){1'b0}}, mean};
    assign sq_next      = val_wide * val_wide;
    assign mean_sq_next = mean_wide * mean_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r3_ctl_reg <= '0;
            r4_ctl_reg <= '0;
        end else if (adv) begin
            r3_ctl_reg <= r2_ctl;
            r4_ctl_reg <= r3_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r3_word_reg    <= r2_word;
            r3_sq_reg      <= sq_next;
            r3_outlier_reg <= (distance >= deviation_limit);
            r4_word_reg    <= r3_word_reg;

            if (r2_ctl.valid && r2_ctl.kind == post_pkg::KIND_MAGIC) begin
                sum_reg <= '0;
            end else if (r2_ctl.valid && r2_ctl.kind == post_pkg::KIND_LOW) begin
                sum_reg <= sum_reg + {3'b000, r2_val};
            end

            if (r3_ctl_reg.valid) begin
                if (r3_ctl_reg.kind == post_pkg::KIND_MAGIC) begin
                    square_sum_reg <= '0;
                    count_reg      <= '0;
                end else if (r3_ctl_reg.kind == post_pkg::KIND_LOW) begin
                    square_sum_reg <= square_sum_reg + r3_sq_reg;
                end else if (r3_ctl_reg.kind == post_pkg::KIND_HIGH && r3_outlier_reg) begin
                    count_reg <= count_reg + 4'd1;
                end
                // sum now holds all eight low samples
                if (r3_ctl_reg.close_low) begin
                    mean_sq_reg <= mean_sq_next;
                end
            end
        end
    end

    assign r4_ctl           = r4_ctl_reg;
    assign r4_word          = r4_word_reg;
    assign stats.square_sum = square_sum_reg;
    assign stats.mean_sq    = mean_sq_reg;
    assign stats.count      = count_reg;

endmodule

FILE: sv/post_verdict.sv
// ---------------------------------------------------------------------------
// post_verdict
// Spread, record eligibility and the result register.
// ---------------------------------------------------------------------------
module post_verdict (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        out_ready,
    input  logic [post_pkg::CFG_W-1:0]  spread_weight,
    input  post_pkg::item_ctl_t         r4_ctl,
    input  logic [post_pkg::WORD_W-1:0] r4_word,
    input  post_pkg::stats_t            stats,
    output logic                        out_valid,
    output post_pkg::out_item_t         out_item
);

    logic                        eligible_reg;
    logic [post_pkg::WORD_W-1:0] held_tag_reg;
    logic [post_pkg::WORD_W-1:0] spread_reg;
    logic                        out_valid_reg;
    post_pkg::out_item_t         out_item_reg;

    logic [post_pkg::CFG_W+post_pkg::COUNT_W-1:0] lhs;
    logic [post_pkg::WORD_W-1:0]                  rhs;
    logic                                         exceeded;
    post_pkg::out_item_t                          item_next;

    assign lhs      = {{post_pkg::COUNT_W{1'b0}}, spread_weight}
                    * {{post_pkg::CFG_W{1'b0}}, stats.count};
    assign rhs      = {spread_reg[post_pkg::WORD_W-4:0], 3'b000};
    assign exceeded = {{(post_pkg::WORD_W-post_pkg::CFG_W-post_pkg::COUNT_W){1'b0}}, lhs} > rhs;

    always_comb begin
        if (!eligible_reg) begin
            item_next.verdict = post_pkg::VERDICT_UNTOUCHED;
            item_next.tag_out = held_tag_reg;
        end else if (exceeded) begin
            item_next.verdict = post_pkg::VERDICT_EXCEEDED;
            item_next.tag_out = {62'd0, post_pkg::VERDICT_EXCEEDED};
        end else begin
            item_next.verdict = post_pkg::VERDICT_WITHIN;
            item_next.tag_out = {62'd0, post_pkg::VERDICT_WITHIN};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            eligible_reg  <= 1'b0;
        end else if (adv) begin
            if (r4_ctl.valid && r4_ctl.close_rec) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (r4_ctl.valid && r4_ctl.kind == post_pkg::KIND_MAGIC) begin
                eligible_reg <= (r4_word == post_pkg::RECORD_MARK);
            end else if (r4_ctl.valid && r4_ctl.kind == post_pkg::KIND_TAG
                         && r4_word != '0) begin
                eligible_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (r4_ctl.valid && r4_ctl.close_rec) begin
                out_item_reg <= item_next;
            end
            if (r4_ctl.valid && r4_ctl.kind == post_pkg::KIND_MAGIC) begin
                held_tag_reg <= '0;
            end else if (r4_ctl.valid && r4_ctl.kind == post_pkg::KIND_TAG) begin
                held_tag_reg <= r4_word;
            end
            if (r4_ctl.valid && r4_ctl.close_low) begin
                spread_reg <= (stats.square_sum >> 3) - stats.mean_sq;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: sv/packet_outlier_spread_test_unit.sv
// ---------------------------------------------------------------------------
// packet_outlier_spread_test_unit
// Streams 18-word records and gives one spread verdict per complete record.
// ---------------------------------------------------------------------------
//
//   Channel  Prefix  Payload               Direction
//   input    s_      word, first           in  (valid/ready)
//   result   m_      verdict, tag_out      out (valid/ready)
//   config   cfg_    index, data           in  (write enable only)
//
// Takes one item per cycle while s_ready is high. A record's result passes
// through the input register, conversion, sum/square, square sum/count and
// result register before it shows on m_. Reset (aresetn low at a clock edge)
// clears the record position, all pipeline valid bits, the result valid and
// loads the register defaults. A waiting result does not block the input;
// only when the next result reaches the last pipeline stage while one still
// waits with m_ready low does the whole pipeline hold and s_ready drop.
//
`include "assert_macros.svh"

module packet_outlier_spread_test_unit (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  post_pkg::in_item_t  s_item,

    output logic                m_valid,
    input  logic                m_ready,
    output post_pkg::out_item_t m_item,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    // Configuration registers.
    logic [post_pkg::CFG_W-1:0] deviation_limit_reg;
    logic [post_pkg::CFG_W-1:0] spread_weight_reg;

    // Pipeline advance: hold only when a new result would overwrite a waiting one.
    logic adv;

    post_pkg::item_ctl_t         r1_ctl;
    logic [post_pkg::WORD_W-1:0] r1_word;
    post_pkg::item_ctl_t         r2_ctl;
    logic [post_pkg::WORD_W-1:0] r2_word;
    logic [post_pkg::FIX_W-1:0]  r2_val;
    post_pkg::item_ctl_t         r4_ctl;
    logic [post_pkg::WORD_W-1:0] r4_word;
    post_pkg::stats_t            stats;

    assign adv     = !(m_valid && !m_ready && r4_ctl.valid && r4_ctl.close_rec);
    assign s_ready = adv;

    // Write a register; writes must arrive only while no record is in flight (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deviation_limit_reg <= post_pkg::DEVIATION_LIMIT_RESET;
            spread_weight_reg   <= post_pkg::SPREAD_WEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                post_pkg::CFG_DEVIATION_LIMIT: deviation_limit_reg <= cfg_data;
                post_pkg::CFG_SPREAD_WEIGHT:   spread_weight_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Track the record position and register the item.
    post_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .s_valid (s_valid),
        .s_item  (s_item),
        .r1_ctl  (r1_ctl),
        .r1_word (r1_word)
    );

    // Turn sample bits into fixed point.
    post_convert u_convert (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .r1_ctl  (r1_ctl),
        .r1_word (r1_word),
        .r2_ctl  (r2_ctl),
        .r2_word (r2_word),
        .r2_val  (r2_val)
    );

    // Accumulate the low samples, count outliers among the high ones.
    post_stats u_stats (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .deviation_limit (deviation_limit_reg),
        .r2_ctl          (r2_ctl),
        .r2_word         (r2_word),
        .r2_val          (r2_val),
        .r4_ctl          (r4_ctl),
        .r4_word         (r4_word),
        .stats           (stats)
    );

    // Form the spread, hold the tag, and register the verdict.
    post_verdict u_verdict (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .out_ready     (m_ready),
        .spread_weight (spread_weight_reg),
        .r4_ctl        (r4_ctl),
        .r4_word       (r4_word),
        .stats         (stats),
        .out_valid     (m_valid),
        .out_item      (m_item)
    );

    // A tested record carries its verdict code as the tag.
    `ASSERT_IMPLIES(a_tested_tag, aclk, aresetn, m_valid && m_item.verdict != post_pkg::VERDICT_UNTOUCHED, m_item.tag_out[63:2] == 62'd0 && m_item.tag_out[1:0] == m_item.verdict, "tested record tag differs from verdict")

    // Only the three defined verdicts leave the block.
    `ASSERT_IMPLIES(a_verdict_code, aclk, aresetn, m_valid, m_item.verdict == post_pkg::VERDICT_UNTOUCHED || m_item.verdict == post_pkg::VERDICT_EXCEEDED || m_item.verdict == post_pkg::VERDICT_WITHIN, "undefined verdict code")

    // A result taken without a new one behind it leaves the output empty.
    `ASSERT_NEXT(a_result_drains, aclk, aresetn, m_valid && m_ready && !(r4_ctl.valid && r4_ctl.close_rec), !m_valid, "result repeated after it was taken")

endmodule
